### src/vf_six_phase_sine_pwm_top_defines.svh
// Assertion macros shared by the six-phase sine PWM block
`ifndef VF_SIX_PHASE_SINE_PWM_TOP_DEFINES_SVH
`define VF_SIX_PHASE_SINE_PWM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define VSPWM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("vspwm assertion failed");
`define VSPWM_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("vspwm illegal condition");
`else
`define VSPWM_ASSERT(lbl, prop)
`define VSPWM_NEVER(lbl, expr)
`endif
`endif

### src/vspwm_pkg.sv
// Types, constants and the quarter-wave sine ROM of the six-phase sine PWM block
package vspwm_pkg;

    localparam int SINE_DEPTH = 1024;
    localparam int DUTY_BITS  = 16;
    localparam int ADDR_W     = $clog2(SINE_DEPTH);

    localparam logic [15:0] DUTY_MASK    = 16'hFFFF << (16 - DUTY_BITS);
    localparam logic [15:0] DUTY_MID     = 16'h8000;
    localparam logic [15:0] OVERRIDE_MIN = 16'd66;
    localparam logic [31:0] TURN_THIRD      = 32'd1431655765;
    localparam logic [31:0] TURN_TWO_THIRDS = 32'd2863311531;

    localparam logic [3:0] CFG_PHASE_PER_HZ   = 4'd0;
    localparam logic [3:0] CFG_WINDING_OFFSET = 4'd1;
    localparam logic [3:0] CFG_VF_BASE_FREQ   = 4'd2;
    localparam logic [3:0] CFG_VF_MOD_MIN     = 4'd3;
    localparam logic [3:0] CFG_VF_MOD_AT_BASE = 4'd4;
    localparam logic [3:0] CFG_MOD_MAX        = 4'd5;
    localparam logic [3:0] CFG_CURRENT_LIMIT  = 4'd6;
    localparam logic [3:0] CFG_CURRENT_GOAL   = 4'd7;

    typedef struct packed {
        logic [23:0] phase_per_hz;
        logic [31:0] winding_offset;
        logic [13:0] vf_base_freq;
        logic [15:0] vf_mod_min;
        logic [15:0] vf_mod_at_base;
        logic [15:0] mod_max;
        logic [14:0] current_limit;
        logic [14:0] current_goal;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PEAK,
        ST_MUL_RAMP,
        ST_DIV_RAMP_GO,
        ST_DIV_RAMP_WAIT,
        ST_MUL_FOLD,
        ST_DIV_FOLD_GO,
        ST_DIV_FOLD_WAIT,
        ST_MOD,
        ST_MUL_STEP,
        ST_PHASE,
        ST_LANE_ADDR,
        ST_LANE_ROM,
        ST_LANE_MUL,
        ST_LANE_STORE,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RAMP,
        MUL_FOLD,
        MUL_STEP,
        MUL_DUTY
    } t_mul_op;

    typedef struct packed {
        logic       capture;
        logic       calc_peak;
        t_mul_op    mul_op;
        logic       div_start;
        logic       div_fold;
        logic       save_ramp;
        logic       set_mod;
        logic       set_phase;
        logic       lane_addr;
        logic       rom_read;
        logic       lane_store;
        logic       publish;
        logic [2:0] lane;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_dp_sts;

    typedef logic [SINE_DEPTH-1:0][15:0] t_sine_rom;

    // floor quotient by shift and subtract, used while building the ROM
    function automatic logic [63:0] div_floor(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q2.30 odd polynomial, each Horner step truncated
    function automatic logic [63:0] poly_sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] dv;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824;
        for (int i = 0; i < 6; i++) begin
            case (i)
                0: dv = 64'd156;
                1: dv = 64'd110;
                2: dv = 64'd72;
                3: dv = 64'd42;
                4: dv = 64'd20;
                default: dv = 64'd6;
            endcase
            t = 64'd1073741824 - div_floor((x2 * t) >> 30, dv);
        end
        return (x * t) >> 30;
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] v;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            x = (64'(i) * 64'd1686629713) >> ADDR_W;
            s = poly_sin_q30(x);
            v = (s * 64'd65535 + (64'd1 << 29)) >> 30;
            rom[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

### src/vf_six_phase_sine_pwm_top.sv
// Top level of the six-phase open-loop V/f sine PWM generator
// One input item per PWM tick gives one result item of six duty cycles for two
// three-phase windings, the index applied and a fold-back flag. Items are
// handled one at a time: two passes of the shared restoring divider (V/f ramp,
// current fold-back), then six sine lanes that each go through an address step,
// a read of the registered sine ROM, the shared multiplier and a store. A finished
// result waits in the output register, so the next item is taken while it is still
// unread. Configuration writes are always accepted and belong to idle periods.
module vf_six_phase_sine_pwm_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [3:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // freq_setpoint, mod_override, current_u1, current_v1, current_w1,
    // current_u2, current_v2, current_w2, zero pad
    input  logic [127:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // duty_u1, duty_v1, duty_w1, duty_u2, duty_v2, duty_w2, applied_mod
    output logic [111:0]  m_axis_tdata,
    // limit_active
    output logic          m_axis_tuser
);

    vspwm_pkg::t_cfg    cfg;
    vspwm_pkg::t_dp_cmd cmd;
    vspwm_pkg::t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    vspwm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vspwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vspwm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

### src/vspwm_cfg.sv
// Configuration register file
module vspwm_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [3:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output vspwm_pkg::t_cfg      o_cfg
);

    vspwm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_per_hz   <= 24'd214748;
            r_cfg.winding_offset <= 32'd1073741824;
            r_cfg.vf_base_freq   <= 14'd3840;
            r_cfg.vf_mod_min     <= 16'd7864;
            r_cfg.vf_mod_at_base <= 16'd55706;
            r_cfg.mod_max        <= 16'd55706;
            r_cfg.current_limit  <= 15'd8960;
            r_cfg.current_goal   <= 15'd6400;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vspwm_pkg::CFG_PHASE_PER_HZ:   r_cfg.phase_per_hz   <= i_cfg_data[23:0];
                vspwm_pkg::CFG_WINDING_OFFSET: r_cfg.winding_offset <= i_cfg_data;
                vspwm_pkg::CFG_VF_BASE_FREQ:   r_cfg.vf_base_freq   <= i_cfg_data[13:0];
                vspwm_pkg::CFG_VF_MOD_MIN:     r_cfg.vf_mod_min     <= i_cfg_data[15:0];
                vspwm_pkg::CFG_VF_MOD_AT_BASE: r_cfg.vf_mod_at_base <= i_cfg_data[15:0];
                vspwm_pkg::CFG_MOD_MAX:        r_cfg.mod_max        <= i_cfg_data[15:0];
                vspwm_pkg::CFG_CURRENT_LIMIT:  r_cfg.current_limit  <= i_cfg_data[14:0];
                vspwm_pkg::CFG_CURRENT_GOAL:   r_cfg.current_goal   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/vspwm_div.sv
// Restoring divider, one quotient bit per cycle
module vspwm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [16:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quot
);

    logic [5:0]  r_cnt;
    logic [16:0] r_rem;
    logic [31:0] r_quot;
    logic [16:0] r_dvs;
    logic [17:0] rem_sh;
    logic [17:0] rem_dif;
    logic        fits;

    assign rem_sh  = {r_rem, r_quot[31]};
    assign rem_dif = rem_sh - {1'b0, r_dvs};
    assign fits    = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_cnt != 6'd0) begin
            r_rem  <= fits ? rem_dif[16:0] : rem_sh[16:0];
            r_quot <= {r_quot[30:0], fits};
        end
    end

    assign o_busy = r_cnt != 6'd0;
    assign o_quot = r_quot;

endmodule

### src/vspwm_ctrl.sv
// Sequencing state machine of the sine PWM block
`include "vf_six_phase_sine_pwm_top_defines.svh"
module vspwm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vspwm_pkg::t_dp_sts  i_sts,
    output vspwm_pkg::t_dp_cmd  o_cmd
);

    vspwm_pkg::t_state r_state;
    vspwm_pkg::t_state n_state;
    logic [2:0]        r_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vspwm_pkg::ST_IDLE;
            r_lane  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == vspwm_pkg::ST_IDLE) begin
                r_lane <= '0;
            end else if (r_state == vspwm_pkg::ST_LANE_STORE) begin
                r_lane <= (r_lane == 3'd5) ? 3'd0 : r_lane + 3'd1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            vspwm_pkg::ST_IDLE:          if (i_in_valid) n_state = vspwm_pkg::ST_PEAK;
            vspwm_pkg::ST_PEAK:          n_state = vspwm_pkg::ST_MUL_RAMP;
            vspwm_pkg::ST_MUL_RAMP:      n_state = vspwm_pkg::ST_DIV_RAMP_GO;
            vspwm_pkg::ST_DIV_RAMP_GO:   n_state = vspwm_pkg::ST_DIV_RAMP_WAIT;
            vspwm_pkg::ST_DIV_RAMP_WAIT: if (!i_sts.div_busy) n_state = vspwm_pkg::ST_MUL_FOLD;
            vspwm_pkg::ST_MUL_FOLD:      n_state = vspwm_pkg::ST_DIV_FOLD_GO;
            vspwm_pkg::ST_DIV_FOLD_GO:   n_state = vspwm_pkg::ST_DIV_FOLD_WAIT;
            vspwm_pkg::ST_DIV_FOLD_WAIT: if (!i_sts.div_busy) n_state = vspwm_pkg::ST_MOD;
            vspwm_pkg::ST_MOD:           n_state = vspwm_pkg::ST_MUL_STEP;
            vspwm_pkg::ST_MUL_STEP:      n_state = vspwm_pkg::ST_PHASE;
            vspwm_pkg::ST_PHASE:         n_state = vspwm_pkg::ST_LANE_ADDR;
            vspwm_pkg::ST_LANE_ADDR:     n_state = vspwm_pkg::ST_LANE_ROM;
            vspwm_pkg::ST_LANE_ROM:      n_state = vspwm_pkg::ST_LANE_MUL;
            vspwm_pkg::ST_LANE_MUL:      n_state = vspwm_pkg::ST_LANE_STORE;
            vspwm_pkg::ST_LANE_STORE: begin
                n_state = (r_lane == 3'd5) ? vspwm_pkg::ST_DONE : vspwm_pkg::ST_LANE_ADDR;
            end
            vspwm_pkg::ST_DONE:          if (i_sts.out_free) n_state = vspwm_pkg::ST_IDLE;
            default:                     n_state = vspwm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.lane = r_lane;
        o_in_ready = 1'b0;
        case (r_state)
            vspwm_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            vspwm_pkg::ST_PEAK:        o_cmd.calc_peak = 1'b1;
            vspwm_pkg::ST_MUL_RAMP:    o_cmd.mul_op = vspwm_pkg::MUL_RAMP;
            vspwm_pkg::ST_DIV_RAMP_GO: o_cmd.div_start = 1'b1;
            vspwm_pkg::ST_MUL_FOLD: begin
                o_cmd.mul_op    = vspwm_pkg::MUL_FOLD;
                o_cmd.save_ramp = 1'b1;
            end
            vspwm_pkg::ST_DIV_FOLD_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_fold  = 1'b1;
            end
            vspwm_pkg::ST_MOD:        o_cmd.set_mod = 1'b1;
            vspwm_pkg::ST_MUL_STEP:   o_cmd.mul_op = vspwm_pkg::MUL_STEP;
            vspwm_pkg::ST_PHASE:      o_cmd.set_phase = 1'b1;
            vspwm_pkg::ST_LANE_ADDR:  o_cmd.lane_addr = 1'b1;
            vspwm_pkg::ST_LANE_ROM:   o_cmd.rom_read = 1'b1;
            vspwm_pkg::ST_LANE_MUL:   o_cmd.mul_op = vspwm_pkg::MUL_DUTY;
            vspwm_pkg::ST_LANE_STORE: o_cmd.lane_store = 1'b1;
            vspwm_pkg::ST_DONE:       o_cmd.publish = i_sts.out_free;
            default: ;
        endcase
    end

    `VSPWM_ASSERT(a_capture_starts, o_cmd.capture |=> (r_state == vspwm_pkg::ST_PEAK))
    `VSPWM_NEVER(a_lane_range, r_lane > 3'd5)
    `VSPWM_ASSERT(a_publish_ends, o_cmd.publish |=> (r_state == vspwm_pkg::ST_IDLE))

endmodule

### src/vspwm_dp.sv
// Datapath: shared multiplier, divider, modulation logic, phase and sine lanes
module vspwm_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vspwm_pkg::t_cfg     i_cfg,
    input  vspwm_pkg::t_dp_cmd  i_cmd,
    output vspwm_pkg::t_dp_sts  o_sts,
    input  logic [127:0]        i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [111:0]        o_out_data,
    output logic                o_out_user
);

    localparam int AW = vspwm_pkg::ADDR_W;

    logic signed [14:0] r_f;
    logic [15:0]        r_ovr;
    logic [15:0]        r_cur [6];
    logic [14:0]        r_absf;
    logic [16:0]        r_peak;
    logic [39:0]        r_prod;
    logic [31:0]        r_q_ramp;
    logic [15:0]        r_last_mod;
    logic               r_limited;
    logic [31:0]        r_phase;
    logic [AW-1:0]      r_rom_addr;
    logic               r_full;
    logic               r_sneg;
    logic [15:0]        r_rom_q;
    logic [15:0]        r_duty [6];
    logic               r_out_valid;
    logic [111:0]       r_out_data;
    logic               r_out_user;

    // peak of the six currents, -32768 counts as 32768
    logic [16:0] cur_abs [6];
    logic [16:0] peak_c;
    always_comb begin
        peak_c = '0;
        for (int i = 0; i < 6; i++) begin
            cur_abs[i] = r_cur[i][15] ? (17'd0 - {r_cur[i][15], r_cur[i]})
                                      : {1'b0, r_cur[i]};
            if (cur_abs[i] > peak_c) peak_c = cur_abs[i];
        end
    end

    logic [16:0] delta;
    logic        delta_neg;
    logic [15:0] delta_mag;
    assign delta     = {1'b0, i_cfg.vf_mod_at_base} - {1'b0, i_cfg.vf_mod_min};
    assign delta_neg = delta[16];
    assign delta_mag = delta_neg ? (16'd0 - delta[15:0]) : delta[15:0];

    // shared multiplier
    logic [23:0] mul_a;
    logic [15:0] mul_b;
    logic [15:0] mag;
    assign mag = r_full ? 16'hFFFF : r_rom_q;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_op)
            vspwm_pkg::MUL_RAMP: begin
                mul_a = {8'd0, delta_mag};
                mul_b = {1'b0, r_absf};
            end
            vspwm_pkg::MUL_FOLD: begin
                mul_a = {8'd0, r_last_mod};
                mul_b = {1'b0, i_cfg.current_goal};
            end
            vspwm_pkg::MUL_STEP: begin
                mul_a = i_cfg.phase_per_hz;
                mul_b = {1'b0, r_absf};
            end
            vspwm_pkg::MUL_DUTY: begin
                mul_a = {8'd0, r_last_mod};
                mul_b = mag;
            end
            default: ;
        endcase
    end

    logic        div_busy;
    logic [31:0] div_quot;
    vspwm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod[31:0]),
        .i_divisor  (i_cmd.div_fold ? r_peak : {3'd0, i_cfg.vf_base_freq}),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    // modulation index: V/f ramp, override, fold-back, ceiling
    logic [16:0] ramp;
    logic [15:0] want;
    logic        fold_hit;
    logic [15:0] mod_sel;
    logic [15:0] mod_new;
    always_comb begin
        ramp = delta_neg ? ({1'b0, i_cfg.vf_mod_min} - {1'b0, r_q_ramp[15:0]})
                         : ({1'b0, i_cfg.vf_mod_min} + {1'b0, r_q_ramp[15:0]});
        want = (r_absf >= {1'b0, i_cfg.vf_base_freq}) ? i_cfg.vf_mod_at_base : ramp[15:0];
        if (r_ovr >= vspwm_pkg::OVERRIDE_MIN) want = r_ovr;
        fold_hit = (r_peak > {2'd0, i_cfg.current_limit})
                && (r_last_mod >= vspwm_pkg::OVERRIDE_MIN)
                && (div_quot < {16'd0, want});
        mod_sel = fold_hit ? div_quot[15:0] : want;
        mod_new = (mod_sel > i_cfg.mod_max) ? i_cfg.mod_max : mod_sel;
    end

    // lane angle and quarter-wave address
    logic [31:0]   lane_base;
    logic [31:0]   lane_angle;
    logic [AW+1:0] pos;
    logic [AW:0]   idx;
    always_comb begin
        lane_base = (i_cmd.lane >= 3'd3) ? (r_phase + i_cfg.winding_offset) : r_phase;
        case (i_cmd.lane)
            3'd1, 3'd4: lane_angle = lane_base - vspwm_pkg::TURN_THIRD;
            3'd2, 3'd5: lane_angle = lane_base - vspwm_pkg::TURN_TWO_THIRDS;
            default:    lane_angle = lane_base;
        endcase
        pos = lane_angle[31 -: AW+2];
        idx = pos[AW] ? ((AW+1)'(vspwm_pkg::SINE_DEPTH) - {1'b0, pos[AW-1:0]})
                      : {1'b0, pos[AW-1:0]};
    end

    // duty value and destination; reverse rotation swaps U and W
    logic [15:0] half;
    logic [17:0] duty_s;
    logic [15:0] duty_sat;
    logic [15:0] duty_q;
    logic [2:0]  dest;
    always_comb begin
        half   = r_prod[32:17];
        duty_s = r_sneg ? ({2'b00, vspwm_pkg::DUTY_MID} - {2'b00, half})
                        : ({2'b00, vspwm_pkg::DUTY_MID} + {2'b00, half});
        if (duty_s[17])               duty_sat = 16'd0;
        else if (duty_s[16])          duty_sat = 16'hFFFF;
        else                          duty_sat = duty_s[15:0];
        if (r_f == 15'sd0) duty_sat = vspwm_pkg::DUTY_MID;
        duty_q = duty_sat & vspwm_pkg::DUTY_MASK;
        case (i_cmd.lane)
            3'd0:    dest = r_f[14] ? 3'd2 : 3'd0;
            3'd1:    dest = 3'd1;
            3'd2:    dest = r_f[14] ? 3'd0 : 3'd2;
            3'd3:    dest = r_f[14] ? 3'd5 : 3'd3;
            3'd4:    dest = 3'd4;
            default: dest = r_f[14] ? 3'd3 : 3'd5;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_mod <= '0;
            r_phase    <= '0;
        end else begin
            if (i_cmd.set_mod) r_last_mod <= mod_new;
            if (i_cmd.set_phase) begin
                r_phase <= r_f[14] ? (r_phase - r_prod[39:8]) : (r_phase + r_prod[39:8]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_f   <= i_in_data[14:0];
            r_ovr <= i_in_data[30:15];
            for (int i = 0; i < 6; i++) r_cur[i] <= i_in_data[31 + 16*i +: 16];
        end
        if (i_cmd.calc_peak) begin
            r_peak <= peak_c;
            r_absf <= r_f[14] ? (15'd0 - r_f) : r_f;
        end
        if (i_cmd.mul_op != vspwm_pkg::MUL_NONE) r_prod <= 40'(mul_a) * 40'(mul_b);
        if (i_cmd.save_ramp) r_q_ramp <= div_quot;
        if (i_cmd.set_mod) r_limited <= fold_hit;
        if (i_cmd.lane_addr) begin
            r_rom_addr <= idx[AW-1:0];
            r_full     <= idx[AW];
            r_sneg     <= pos[AW+1];
        end
        if (i_cmd.rom_read) r_rom_q <= vspwm_pkg::SINE_ROM[r_rom_addr];
        if (i_cmd.lane_store) r_duty[dest] <= duty_q;
    end

    // output register, holds while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_data <= {r_last_mod, r_duty[5], r_duty[4], r_duty[3],
                           r_duty[2], r_duty[1], r_duty[0]};
            r_out_user <= r_limited;
        end
    end

    assign o_sts.div_busy = div_busy;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;
    assign o_out_user     = r_out_user;

endmodule

### bench/testbench.sv
// Self-checking bench for the six-phase V/f sine PWM block against a bit-exact predictor
module testbench;

    // an index past the register file, written to check it is ignored
    localparam logic [3:0] CFG_SPARE = 4'd9;

    typedef struct {
        logic signed [14:0] freq;
        logic [15:0]        ovr;
        logic [5:0][15:0]   amps;
        bit                 typed;
        logic [15:0]        duty;
        logic [15:0]        imod;
        logic               lim;
    } t_row;

    typedef struct {
        logic [5:0][15:0] duty;
        logic [15:0]      imod;
        logic             lim;
    } t_tick;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic [3:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         o_cfg_ready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tuser;

    vf_six_phase_sine_pwm_top dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    vspwm_pkg::t_cfg cfg;
    logic [31:0]     angle;
    logic [15:0]     prev_mod;
    logic [15:0]     sine_q[vspwm_pkg::SINE_DEPTH];
    t_tick           expected_ticks[$];
    int              mismatches = 0;
    int              hold_off = 0;

    function automatic longint unsigned horner_sin(longint unsigned x);
        longint unsigned x2, t;
        longint unsigned dvs[6] = '{156, 110, 72, 42, 20, 6};
        x2 = (x * x) >> 30;
        t = 64'd1073741824;
        for (int i = 0; i < 6; i++)
            t = 64'd1073741824 - ((x2 * t) >> 30) / dvs[i];
        return (x * t) >> 30;
    endfunction

    function automatic void fill_sine();
        longint unsigned x, v;
        for (int i = 0; i < vspwm_pkg::SINE_DEPTH; i++) begin
            x = (longint'(i) * 64'd1686629713) / vspwm_pkg::SINE_DEPTH;
            v = (horner_sin(x) * 65535 + (64'd1 << 29)) >> 30;
            sine_q[i] = (v > 65535) ? 16'hFFFF : v[15:0];
        end
    endfunction

    function automatic void cfg_defaults();
        cfg.phase_per_hz   = 24'd214748;
        cfg.winding_offset = 32'd1073741824;
        cfg.vf_base_freq   = 14'd3840;
        cfg.vf_mod_min     = 16'd7864;
        cfg.vf_mod_at_base = 16'd55706;
        cfg.mod_max        = 16'd55706;
        cfg.current_limit  = 15'd8960;
        cfg.current_goal   = 15'd6400;
        angle = '0;
        prev_mod = '0;
    endfunction

    function automatic longint sine_at(logic [31:0] a);
        longint unsigned p, quad, k, idx;
        longint mag;
        p = (longint'(a) * (4 * vspwm_pkg::SINE_DEPTH)) >> 32;
        quad = (p / vspwm_pkg::SINE_DEPTH) & 3;
        k = p % vspwm_pkg::SINE_DEPTH;
        idx = quad[0] ? vspwm_pkg::SINE_DEPTH - k : k;
        mag = (idx >= vspwm_pkg::SINE_DEPTH) ? 65535 : sine_q[idx];
        return quad[1] ? -mag : mag;
    endfunction

    function automatic logic [15:0] duty_of(logic [15:0] m, logic [31:0] a, bit run);
        longint d, s, half;
        d = 32768;
        if (run) begin
            s = sine_at(a);
            half = (longint'(m) * (s < 0 ? -s : s)) >> 17;
            d = (s < 0) ? d - half : d + half;
        end
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        return d[15:0] & vspwm_pkg::DUTY_MASK;
    endfunction

    function automatic t_tick next_tick(logic signed [14:0] f, logic [15:0] ovr,
                                        logic [5:0][15:0] amps);
        t_tick r;
        longint fa, want, peak, a, safe, step;
        logic [31:0] t1, t2;
        bit back;
        fa = (f < 0) ? -longint'(f) : longint'(f);
        if (fa >= cfg.vf_base_freq)
            want = cfg.vf_mod_at_base;
        else
            want = longint'(cfg.vf_mod_min) + ((longint'(cfg.vf_mod_at_base)
                   - longint'(cfg.vf_mod_min)) * fa) / longint'(cfg.vf_base_freq);
        if (ovr >= vspwm_pkg::OVERRIDE_MIN) want = ovr;
        peak = 0;
        for (int i = 0; i < 6; i++) begin
            a = longint'($signed(amps[i]));
            if (a < 0) a = -a;
            if (a > peak) peak = a;
        end
        r.lim = 1'b0;
        if (peak > cfg.current_limit && prev_mod >= vspwm_pkg::OVERRIDE_MIN) begin
            safe = (longint'(prev_mod) * cfg.current_goal) / peak;
            if (safe < want) begin
                want = safe;
                r.lim = 1'b1;
            end
        end
        if (want > cfg.mod_max) want = cfg.mod_max;
        prev_mod = want[15:0];
        step = (fa * cfg.phase_per_hz) >> 8;
        angle = (f < 0) ? angle - step[31:0] : angle + step[31:0];
        t1 = angle;
        t2 = angle + cfg.winding_offset;
        back = (f < 0);
        r.duty[back ? 2 : 0] = duty_of(prev_mod, t1, f != 0);
        r.duty[1]            = duty_of(prev_mod, t1 - vspwm_pkg::TURN_THIRD, f != 0);
        r.duty[back ? 0 : 2] = duty_of(prev_mod, t1 - vspwm_pkg::TURN_TWO_THIRDS, f != 0);
        r.duty[back ? 5 : 3] = duty_of(prev_mod, t2, f != 0);
        r.duty[4]            = duty_of(prev_mod, t2 - vspwm_pkg::TURN_THIRD, f != 0);
        r.duty[back ? 3 : 5] = duty_of(prev_mod, t2 - vspwm_pkg::TURN_TWO_THIRDS, f != 0);
        r.imod = prev_mod;
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 20);
    endfunction

    // valid stays up after an item unless a gap follows
    task automatic send_tick(logic signed [14:0] f, logic [15:0] ovr,
                             logic [5:0][15:0] amps, bit typed, t_tick fixed);
        t_tick e;
        int    n;
        n = gap_len();
        if (n > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, amps[5], amps[4], amps[3], amps[2], amps[1], amps[0],
                          ovr, f};
        do @(posedge i_clk); while (!s_axis_tready);
        e = next_tick(f, ovr, amps);
        expected_ticks.push_back(typed ? fixed : e);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            vspwm_pkg::CFG_PHASE_PER_HZ:   cfg.phase_per_hz   = val[23:0];
            vspwm_pkg::CFG_WINDING_OFFSET: cfg.winding_offset = val;
            vspwm_pkg::CFG_VF_BASE_FREQ:   cfg.vf_base_freq   = val[13:0];
            vspwm_pkg::CFG_VF_MOD_MIN:     cfg.vf_mod_min     = val[15:0];
            vspwm_pkg::CFG_VF_MOD_AT_BASE: cfg.vf_mod_at_base = val[15:0];
            vspwm_pkg::CFG_MOD_MAX:        cfg.mod_max        = val[15:0];
            vspwm_pkg::CFG_CURRENT_LIMIT:  cfg.current_limit  = val[14:0];
            vspwm_pkg::CFG_CURRENT_GOAL:   cfg.current_goal   = val[14:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic load_setting(logic [23:0] pph, logic [31:0] offs, logic [13:0] base,
                                logic [15:0] mmin, logic [15:0] mtop, logic [15:0] mmax,
                                logic [14:0] lim, logic [14:0] goal);
        drain();
        write_reg(vspwm_pkg::CFG_PHASE_PER_HZ, 32'(pph));
        write_reg(vspwm_pkg::CFG_WINDING_OFFSET, offs);
        write_reg(vspwm_pkg::CFG_VF_BASE_FREQ, 32'(base));
        write_reg(vspwm_pkg::CFG_VF_MOD_MIN, 32'(mmin));
        write_reg(vspwm_pkg::CFG_VF_MOD_AT_BASE, 32'(mtop));
        write_reg(vspwm_pkg::CFG_MOD_MAX, 32'(mmax));
        write_reg(vspwm_pkg::CFG_CURRENT_LIMIT, 32'(lim));
        write_reg(vspwm_pkg::CFG_CURRENT_GOAL, 32'(goal));
    endtask

    function automatic logic [15:0] rand_amp();
        int r;
        r = $urandom_range(9);
        if (r < 5) return 16'($signed($urandom_range(4000)) - 2000);
        if (r < 6) return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        return 16'($urandom());
    endfunction

    task automatic random_ticks(int count);
        logic signed [14:0] f;
        logic [15:0]        ovr;
        logic [5:0][15:0]   amps;
        t_tick              none;
        none = '{default: '0};
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(5))
                0: f = '0;
                1: f = 15'($urandom_range(600)) - 15'sd300;
                2: f = 15'($urandom_range(8000)) - 15'sd4000;
                default: f = 15'($urandom_range(25600)) - 15'sd12800;
            endcase
            ovr = $urandom_range(1) ? 16'($urandom_range(130)) : 16'($urandom_range(55706));
            for (int i = 0; i < 6; i++) amps[i] = rand_amp();
            send_tick(f, ovr, amps, 1'b0, none);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // drop ready at random; honor a long hold when one is asked for
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                m_axis_tready <= 1'b0;
                hold_off = hold_off - 1;
            end else if ($urandom_range(99) < 10) begin
                m_axis_tready <= 1'b0;
                repeat (gap_len()) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(string fname, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", fname, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_tick e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: unexpected output item");
            end else begin
                e = expected_ticks.pop_front();
                for (int i = 0; i < 6; i++)
                    check_field($sformatf("duty[%0d]", i), e.duty[i], m_axis_tdata[16*i +: 16]);
                check_field("applied_mod", e.imod, m_axis_tdata[111:96]);
                check_field("limit_active", 16'(e.lim), 16'(m_axis_tuser));
            end
        end
    end

    t_row directed[] = '{
        '{15'sd0, 16'd0, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1, 16'd32768, 16'd7864, 0},
        '{15'sd0, 16'd55706, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1, 16'd32768,
          16'd55706, 0},
        '{15'sd0, 16'd65, '{16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5}, 1, 16'd32768, 16'd7864, 0},
        '{15'sd0, 16'd66, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1, 16'd32768, 16'd66, 0},
        '{15'sd1, 16'd0, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 0, 0, 0, 0},
        '{-15'sd1, 16'd0, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 0, 0, 0, 0},
        '{15'sd3839, 16'd0, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 0, 0, 0, 0},
        '{15'sd3840, 16'd0, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 0, 0, 0, 0},
        '{15'sd12800, 16'd0, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 0, 0, 0, 0},
        '{-15'sd12800, 16'd0, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 0, 0, 0, 0},
        '{15'sd5000, 16'd0, '{16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 0, 0, 0, 0},
        '{15'sd5000, 16'd0, '{16'd0, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0}, 0, 0, 0, 0},
        '{-15'sd700, 16'd30000, '{16'd0, 16'd0, 16'd8961, 16'd0, 16'd0, 16'd0}, 0, 0, 0, 0},
        '{15'sd700, 16'd30000, '{16'd0, 16'd0, 16'd0, 16'd8960, 16'd0, 16'd0}, 0, 0, 0, 0},
        '{15'sd1234, 16'd55706, '{16'd0, 16'd0, 16'd0, 16'd0, 16'hDCBA, 16'd0}, 0, 0, 0, 0},
        '{-15'sd4321, 16'd20000, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF}, 0, 0, 0, 0},
        '{15'sd9999, 16'd0, '{16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC, 16'h0F0F, 16'hF0F0},
          0, 0, 0, 0},
        '{-15'sd16, 16'd43690, '{16'hAAAA, 16'h5555, 16'hCCCC, 16'h3333, 16'hF0F0, 16'h0F0F},
          0, 0, 0, 0}
    };

    initial begin
        t_tick fixed;
        fill_sine();
        cfg_defaults();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[r]) begin
            fixed.duty = {6{directed[r].duty}};
            fixed.imod = directed[r].imod;
            fixed.lim  = directed[r].lim;
            send_tick(directed[r].freq, directed[r].ovr, directed[r].amps,
                      directed[r].typed, fixed);
        end
        // stall the output so the block fills up and backs off its input
        hold_off = 800;
        random_ticks(230);
        load_setting(24'hFFFFFF, 32'hFFFFFFFF, 14'd1, 16'd0, 16'hFFFF, 16'hFFFF,
                     15'd0, 15'h7FFF);
        write_reg(CFG_SPARE, 32'hFFFFFFFF);
        random_ticks(250);
        load_setting(24'd0, 32'd0, 14'd12800, 16'hFFFF, 16'd0, 16'd0, 15'h7FFF, 15'd0);
        random_ticks(200);
        for (int p = 0; p < 2; p++) begin
            load_setting(24'($urandom_range(24'hFFFFFF)), $urandom(),
                         14'($urandom_range(12800, 1)),
                         16'($urandom_range(65535)), 16'($urandom_range(65535)),
                         16'($urandom_range(65535)), 15'($urandom_range(32767)),
                         15'($urandom_range(32767)));
            random_ticks(275);
        end
        drain();
        if (mismatches == 0 && expected_ticks.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/vspwm_pkg.sv
src/vspwm_cfg.sv
src/vspwm_div.sv
src/vspwm_ctrl.sv
src/vspwm_dp.sv
src/vf_six_phase_sine_pwm_top.sv
bench/testbench.sv
